// ===== sv/otp_word_program_sequencer_macros.svh =====
// Assertion helpers used by the sequencer module.
`ifndef OTP_WORD_PROGRAM_SEQUENCER_MACROS_SVH
`define OTP_WORD_PROGRAM_SEQUENCER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define OWPS_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("sequencer check failed");

// Check that a condition implies a consequence in the next cycle.
`define OWPS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error("sequencer check failed");

`endif

// ===== sv/owps_pkg.sv =====
package owps_pkg;

	// Default compare width of a device word
	localparam int WORD_BITS_DEF = 12;

	// Input modes
	localparam logic [1:0] MODE_ENTER = 2'd0;
	localparam logic [1:0] MODE_INC   = 2'd1;
	localparam logic [1:0] MODE_PROG  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Result actions
	localparam logic [2:0] ACT_READ  = 3'd0;
	localparam logic [2:0] ACT_PULSE = 3'd1;
	localparam logic [2:0] ACT_BURST = 3'd2;
	localparam logic [2:0] ACT_INC   = 3'd3;
	localparam logic [2:0] ACT_DONE  = 3'd4;

	// Done status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_BLANK_FAIL = 2'd1;
	localparam logic [1:0] STAT_WRITE_FAIL = 2'd2;

	// Sequencer phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_BLANK  = 2'd1;
	localparam logic [1:0] PH_VERIFY = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_MULT   = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;
	localparam logic [1:0] REG_CAL    = 2'd3;

	// Configuration reset values
	localparam logic [4:0]  MULT_RST   = 5'd11;
	localparam logic [4:0]  OFFSET_RST = 5'd0;
	localparam logic [3:0]  LIMIT_RST  = 4'd8;
	localparam logic [11:0] CAL_RST    = 12'hFFF;

	// Literal load opcode in the upper byte
	localparam logic [15:0] LIT_LOAD  = 16'h0C00;
	localparam logic [15:0] HIGH_BYTE = 16'hFF00;

	// Result queue depth: three results of one item plus one draining
	localparam int RQ_DEPTH = 4;

	typedef struct packed {
		logic [2:0]  action;
		logic [11:0] word_out;
		logic [8:0]  burst_count;
		logic [11:0] word_address;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// ===== sv/otp_word_program_sequencer.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+--------------------------------------------
// in       | in_valid / in_stall      | mode, program_word, device_word
// out      | out_valid / out_stall    | action, word_out, burst_count, word_address,
//          |                          | status, last
// cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// An input beat is decoded combinationally and its up to three results are queued.
// One input beat per cycle while each beat gives at most one result and the output is not
// stalled; a beat that gives two or three results holds off further beats, as the input stalls
// while more than one result waits in the four-entry result queue.
// arst_n resets the state and the configuration registers and empties the queue at once.
// Configuration writes are always ready.
`include "otp_word_program_sequencer_macros.svh"

module otp_word_program_sequencer #(
	parameter int WORD_BITS = owps_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] program_word,
	input  logic [11:0] device_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [11:0] word_out,
	output logic [8:0]  burst_count,
	output logic [11:0] word_address,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam logic [15:0] WORD_MASK = 16'((32'd1 << WORD_BITS) - 32'd1);
	localparam logic [15:0] HI_MASK   = WORD_MASK & owps_pkg::HIGH_BYTE;
	localparam int PTR_W = $clog2(owps_pkg::RQ_DEPTH);
	localparam int CNT_W = $clog2(owps_pkg::RQ_DEPTH + 1);

	// Configuration registers
	logic [4:0]  mult_q;
	logic [4:0]  offset_q;
	logic [3:0]  limit_q;
	logic [11:0] cal_q;

	// Sequencer state
	logic [12:0] ptr_q;
	logic [1:0]  phase_q;
	logic [3:0]  pulse_q;
	logic [15:0] pend_q;
	logic [12:0] lastprog_q;

	// Result queue
	owps_pkg::result_t rq_q [owps_pkg::RQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic acc;
	logic pop;

	logic [12:0] ptr_d;
	logic [1:0]  phase_d;
	logic [3:0]  pulse_d;
	logic [15:0] pend_d;
	logic [12:0] lastprog_d;
	logic [1:0]  n_push;
	owps_pkg::result_t r0, r1, r2;

	logic [12:0] ptr_inc;
	logic [15:0] pend_m;
	logic [15:0] dev_m;
	logic        blank;
	logic        lit_load;
	logic [8:0]  burst_cnt;
	owps_pkg::result_t inc_nl;
	owps_pkg::result_t pulse_r;

	assign cfg_ready = 1'b1;
	assign acc       = in_valid & ~in_stall;
	assign in_stall  = cnt_q > CNT_W'(1);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid & ~out_stall;

	assign action       = rq_q[rd_q].action;
	assign word_out     = rq_q[rd_q].word_out;
	assign burst_count  = rq_q[rd_q].burst_count;
	assign word_address = rq_q[rd_q].word_address;
	assign status       = rq_q[rd_q].status;
	assign last         = rq_q[rd_q].last;

	// Shared terms of the decode
	assign ptr_inc   = ptr_q + 13'd1;
	assign pend_m    = pend_q & WORD_MASK;
	assign dev_m     = {4'd0, device_word} & WORD_MASK;
	assign blank     = dev_m == WORD_MASK;
	assign lit_load  = (pend_q & HI_MASK) == (owps_pkg::LIT_LOAD & HI_MASK);
	assign burst_cnt = 9'(pulse_q) * 9'(mult_q) + 9'(offset_q);
	assign inc_nl    = '{owps_pkg::ACT_INC, 12'd0, 9'd0, ptr_inc[11:0],
		owps_pkg::STAT_OK, 1'b0};
	assign pulse_r   = '{owps_pkg::ACT_PULSE, pend_m[11:0], 9'd0, ptr_q[11:0],
		owps_pkg::STAT_OK, 1'b1};

	// Decode one input beat into next state and results
	always_comb begin
		ptr_d      = ptr_q;
		phase_d    = phase_q;
		pulse_d    = pulse_q;
		pend_d     = pend_q;
		lastprog_d = lastprog_q;
		n_push     = 2'd0;
		r0         = '0;
		r1         = '0;
		r2         = '0;
		unique case (mode)
			owps_pkg::MODE_ENTER: begin
				ptr_d   = '1;
				phase_d = owps_pkg::PH_IDLE;
				pulse_d = 4'd0;
			end
			owps_pkg::MODE_INC: begin
				ptr_d   = ptr_inc;
				phase_d = owps_pkg::PH_IDLE;
				r0      = inc_nl;
				r0.last = 1'b1;
				n_push  = 2'd1;
			end
			owps_pkg::MODE_PROG: begin
				pend_d  = program_word;
				pulse_d = 4'd0;
				phase_d = owps_pkg::PH_BLANK;
				r0      = '{owps_pkg::ACT_READ, 12'd0, 9'd0, ptr_q[11:0],
					owps_pkg::STAT_OK, 1'b1};
				n_push  = 2'd1;
			end
			owps_pkg::MODE_READ: begin
				if (phase_q == owps_pkg::PH_BLANK) begin
					// Calibration word: program only a blank cell with a literal load
					if (ptr_q == {1'b0, cal_q} && !(blank && lit_load)) begin
						ptr_d   = ptr_inc;
						phase_d = owps_pkg::PH_IDLE;
						r0      = inc_nl;
						r1      = '{owps_pkg::ACT_DONE, 12'd0, 9'd0, lastprog_q[11:0],
							owps_pkg::STAT_OK, 1'b1};
						n_push  = 2'd2;
					end else if (ptr_q != {1'b0, cal_q} && !blank) begin
						phase_d = owps_pkg::PH_IDLE;
						r0      = '{owps_pkg::ACT_DONE, 12'd0, 9'd0, lastprog_q[11:0],
							owps_pkg::STAT_BLANK_FAIL, 1'b1};
						n_push  = 2'd1;
					end else if (ptr_q != {1'b0, cal_q} && pend_m == WORD_MASK) begin
						// Skip an all-ones word
						ptr_d   = ptr_inc;
						phase_d = owps_pkg::PH_IDLE;
						r0      = inc_nl;
						r1      = '{owps_pkg::ACT_DONE, 12'd0, 9'd0, lastprog_q[11:0],
							owps_pkg::STAT_OK, 1'b1};
						n_push  = 2'd2;
					end else begin
						lastprog_d = ptr_q;
						pulse_d    = 4'd1;
						phase_d    = owps_pkg::PH_VERIFY;
						r0         = pulse_r;
						n_push     = 2'd1;
					end
				end else if (phase_q == owps_pkg::PH_VERIFY) begin
					if (pend_m == dev_m) begin
						// Verified: burst, then increment and done
						ptr_d   = ptr_inc;
						phase_d = owps_pkg::PH_IDLE;
						r0      = '{owps_pkg::ACT_BURST, pend_m[11:0], burst_cnt, ptr_q[11:0],
							owps_pkg::STAT_OK, 1'b0};
						r1      = inc_nl;
						r2      = '{owps_pkg::ACT_DONE, 12'd0, 9'd0, lastprog_q[11:0],
							owps_pkg::STAT_OK, 1'b1};
						n_push  = 2'd3;
					end else if (pulse_q >= limit_q) begin
						ptr_d   = ptr_inc;
						phase_d = owps_pkg::PH_IDLE;
						r0      = inc_nl;
						r1      = '{owps_pkg::ACT_DONE, 12'd0, 9'd0, lastprog_q[11:0],
							owps_pkg::STAT_WRITE_FAIL, 1'b1};
						n_push  = 2'd2;
					end else begin
						pulse_d = pulse_q + 4'd1;
						r0      = pulse_r;
						n_push  = 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q   <= owps_pkg::MULT_RST;
			offset_q <= owps_pkg::OFFSET_RST;
			limit_q  <= owps_pkg::LIMIT_RST;
			cal_q    <= owps_pkg::CAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				owps_pkg::REG_MULT:   mult_q   <= cfg_data[4:0];
				owps_pkg::REG_OFFSET: offset_q <= cfg_data[4:0];
				owps_pkg::REG_LIMIT:  limit_q  <= cfg_data[3:0];
				owps_pkg::REG_CAL:    cal_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance sequencer state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '1;
			phase_q    <= owps_pkg::PH_IDLE;
			pulse_q    <= 4'd0;
			pend_q     <= 16'd0;
			lastprog_q <= 13'd0;
		end else if (acc) begin
			ptr_q      <= ptr_d;
			phase_q    <= phase_d;
			pulse_q    <= pulse_d;
			pend_q     <= pend_d;
			lastprog_q <= lastprog_d;
		end
	end

	// Queue results of the accepted beat
	always_ff @(posedge clk) begin
		if (acc && n_push > 2'd0) begin
			rq_q[wr_q] <= r0;
		end
		if (acc && n_push > 2'd1) begin
			rq_q[wr_q + PTR_W'(1)] <= r1;
		end
		if (acc && n_push > 2'd2) begin
			rq_q[wr_q + PTR_W'(2)] <= r2;
		end
	end

	// Track queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (acc ? CNT_W'(n_push) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	`OWPS_ASSERT_SAME(a_rq_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(owps_pkg::RQ_DEPTH))
	`OWPS_ASSERT_SAME(a_verify_pulse, clk, arst_n, phase_q == owps_pkg::PH_VERIFY, pulse_q != 4'd0)
	`OWPS_ASSERT_NEXT(a_inc_result, clk, arst_n, acc && mode == owps_pkg::MODE_INC, out_valid)

endmodule
